@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the color space converter.
// No dependencies; the bodies compile away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is low.
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define RHC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RHC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/core/rhc_pkg.sv @@
// Shared types and constants of the RGB / HSL / HSV converter.
// No dependencies; used by the top level and both inverse datapaths.
package rhc_pkg;

  localparam int DEF_FRAC_BITS = 12;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 13;
  localparam int THR_W         = 13;
  localparam int THR_RESET     = 4;
  // Pipeline depth of both inverse conversion paths.
  localparam int INV_LAT       = 4;

  typedef enum logic [1:0] {
    OP_RGB2HSL = 2'd0,
    OP_HSL2RGB = 2'd1,
    OP_RGB2HSV = 2'd2,
    OP_HSV2RGB = 2'd3
  } op_e;

  // Hue segment of one HSL channel.
  typedef enum logic [1:0] {
    SEG_RISE = 2'd0,
    SEG_TOP  = 2'd1,
    SEG_FALL = 2'd2,
    SEG_LOW  = 2'd3
  } seg_e;

endpackage

@@ rtl/core/rgb_hsl_hsv_converter.sv @@
// RGB / HSL / HSV converter, top level. Depends on rhc_pkg, rhc_div,
// rhc_hsl_rgb, rhc_hsv_rgb and assert_macros.svh.
//
// Usage: drive op and the three channels with start high; busy stays low, so
// a new beat is taken on every clock. Each beat yields exactly one result
// beat, flagged by done_o for a single cycle. The receiver cannot stall, so
// sample the outputs whenever done_o is high. The latency is set by the two
// forward dividers (saturation and hue), which resolve one quotient bit per
// stage over FRAC_BITS + 1 stages; the inverse paths run four stages and are
// delayed to line up, so results leave in input order. Channels are clamped
// to 0..1.0 on entry. The gray threshold is sampled with each beat; write it
// only while no beat is in flight.
`include "assert_macros.svh"

module rgb_hsl_hsv_converter #(
  parameter int FRAC_BITS = rhc_pkg::DEF_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op_i,
  input  logic signed [rhc_pkg::IN_W-1:0] in_first_i,
  input  logic signed [rhc_pkg::IN_W-1:0] in_second_i,
  input  logic signed [rhc_pkg::IN_W-1:0] in_third_i,
  input  logic                      cfg_we_i,
  input  logic [rhc_pkg::THR_W-1:0] cfg_wdata_i,
  output logic                      done_o,
  output logic [rhc_pkg::OUT_W-1:0] out_first_o,
  output logic [rhc_pkg::OUT_W-1:0] out_second_o,
  output logic [rhc_pkg::OUT_W-1:0] out_third_o
);

  localparam int CW  = FRAC_BITS + 1;
  localparam int ONE = 1 << FRAC_BITS;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = 2 * FRAC_BITS + 4;
  localparam int DW  = FRAC_BITS + 4;
  localparam int DLY = QW + 1 - rhc_pkg::INV_LAT;

  // Forward-path control that rides along the saturation divider.
  typedef struct packed {
    rhc_pkg::op_e              op;
    logic                      gray;   // chroma at or below threshold
    logic                      black;  // max at or below threshold
    logic                      dpos;   // nonzero chroma
    logic [rhc_pkg::THR_W-1:0] thr;
    logic [CW-1:0]             lum;
    logic [CW-1:0]             mx;
  } fwd_sb_t;

  typedef struct packed {
    logic [CW-1:0] l1, l2, l3;   // hsl to rgb
    logic [CW-1:0] v1, v2, v3;   // hsv to rgb
  } inv_t;

  function automatic logic [CW-1:0] clamp_ch(input logic [rhc_pkg::IN_W-1:0] v);
    logic [31:0]   ext;
    logic [CW-1:0] res;
    ext = 32'(v);
    if (v[rhc_pkg::IN_W-1]) begin
      res = '0;
    end else if (ext > 32'(ONE)) begin
      res = CW'(ONE);
    end else begin
      res = ext[CW-1:0];
    end
    return res;
  endfunction

  function automatic logic [rhc_pkg::OUT_W-1:0] out_bits(input logic [CW-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    return ext[rhc_pkg::OUT_W-1:0];
  endfunction

  // Threshold register.
  logic [rhc_pkg::THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= rhc_pkg::THR_W'(rhc_pkg::THR_RESET);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Always ready: the pipeline advances every cycle.
  logic acc;
  assign busy = 1'b0;
  assign acc  = start && !busy;

  // Stage 0: capture and clamp the beat.
  logic                      s0_vld_q;
  rhc_pkg::op_e              s0_op_q;
  logic [CW-1:0]             s0_a_q, s0_b_q, s0_c_q;
  logic [rhc_pkg::THR_W-1:0] s0_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s0_op_q  <= rhc_pkg::op_e'(op_i);
      s0_a_q   <= clamp_ch(in_first_i);
      s0_b_q   <= clamp_ch(in_second_i);
      s0_c_q   <= clamp_ch(in_third_i);
      s0_thr_q <= thr_q;
    end
  end

  // Stage 1: max, min, chroma, hue numerator and divider operands.
  logic [CW-1:0]        mx, mn, dd;
  logic [CW:0]          sum, sum1, den;
  logic signed [CW+3:0] num, nneg;
  logic [CW+2:0]        mag;
  fwd_sb_t              sb_d;

  always_comb begin
    mx = s0_a_q;
    if (s0_b_q > mx) mx = s0_b_q;
    if (s0_c_q > mx) mx = s0_c_q;
    mn = s0_a_q;
    if (s0_b_q < mn) mn = s0_b_q;
    if (s0_c_q < mn) mn = s0_c_q;
    sum  = {1'b0, mx} + {1'b0, mn};
    sum1 = sum + (CW+1)'(1);
    dd   = mx - mn;
    // Hue numerator by the channel holding the max.
    if (s0_a_q >= mx) begin
      num = $signed({4'b0, s0_b_q}) - $signed({4'b0, s0_c_q});
    end else if (s0_b_q >= mx) begin
      num = $signed({3'b0, dd, 1'b0}) + $signed({4'b0, s0_c_q}) - $signed({4'b0, s0_a_q});
    end else begin
      num = $signed({2'b0, dd, 2'b0}) + $signed({4'b0, s0_a_q}) - $signed({4'b0, s0_b_q});
    end
    nneg = -num;
    mag  = num[CW+3] ? nneg[CW+2:0] : num[CW+2:0];
    // Saturation divisor: lightness-based for HSL, max for HSV.
    if (s0_op_q == rhc_pkg::OP_RGB2HSL) begin
      den = (sum < (CW+1)'(ONE)) ? sum : ((CW+1)'(2 * ONE) - sum);
    end else begin
      den = {1'b0, mx};
    end
    sb_d.op    = s0_op_q;
    sb_d.gray  = (32'(dd) <= 32'(s0_thr_q));
    sb_d.black = (32'(mx) <= 32'(s0_thr_q));
    sb_d.dpos  = (dd != '0);
    sb_d.thr   = s0_thr_q;
    sb_d.lum   = sum1[CW:1];
    sb_d.mx    = mx;
  end

  logic          s1_vld_q;
  logic          s1_neg_q;
  logic [NW-1:0] s1_sat_n_q, s1_hue_n_q;
  logic [DW-1:0] s1_sat_d_q, s1_hue_d_q;
  fwd_sb_t       s1_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  // Rounded quotients: divide 2n + d by 2d.
  always_ff @(posedge clk_i) begin
    s1_sb_q    <= sb_d;
    s1_neg_q   <= num[CW+3];
    s1_sat_n_q <= (NW'(dd) << (FRAC_BITS + 1)) + NW'(den);
    s1_sat_d_q <= DW'({den, 1'b0});
    s1_hue_n_q <= (NW'(mag) << (FRAC_BITS + 1)) + (NW'(dd) << 2) + (NW'(dd) << 1);
    s1_hue_d_q <= (DW'(dd) << 3) + (DW'(dd) << 2);
  end

  // Saturation and hue dividers run in lockstep.
  logic          sat_vld, hue_vld, hue_neg;
  logic [QW-1:0] sat_q, hue_q;
  fwd_sb_t       sb_o;

  rhc_div #(
    .NW(NW), .DW(DW), .QW(QW), .SW($bits(fwd_sb_t))
  ) u_sat_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s1_vld_q),
    .num_i  (s1_sat_n_q),
    .den_i  (s1_sat_d_q),
    .sb_i   (s1_sb_q),
    .vld_o  (sat_vld),
    .quo_o  (sat_q),
    .sb_o   (sb_o)
  );

  rhc_div #(
    .NW(NW), .DW(DW), .QW(QW), .SW(1)
  ) u_hue_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s1_vld_q),
    .num_i  (s1_hue_n_q),
    .den_i  (s1_hue_d_q),
    .sb_i   (s1_neg_q),
    .vld_o  (hue_vld),
    .quo_o  (hue_q),
    .sb_o   (hue_neg)
  );

  // Inverse conversions start from stage 0.
  inv_t inv_d;

  rhc_hsl_rgb #(.FRAC_BITS(FRAC_BITS)) u_hsl_rgb (
    .clk_i (clk_i),
    .h_i   (s0_a_q),
    .s_i   (s0_b_q),
    .l_i   (s0_c_q),
    .thr_i (s0_thr_q),
    .r_o   (inv_d.l1),
    .g_o   (inv_d.l2),
    .b_o   (inv_d.l3)
  );

  rhc_hsv_rgb #(.FRAC_BITS(FRAC_BITS)) u_hsv_rgb (
    .clk_i (clk_i),
    .h_i   (s0_a_q),
    .s_i   (s0_b_q),
    .v_i   (s0_c_q),
    .thr_i (s0_thr_q),
    .r_o   (inv_d.v1),
    .g_o   (inv_d.v2),
    .b_o   (inv_d.v3)
  );

  // Delay the inverse results to meet the divider outputs.
  inv_t dly_q [DLY];

  always_ff @(posedge clk_i) begin
    dly_q[0] <= inv_d;
    for (int i = 1; i < DLY; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  // Final select: wrap a negative hue, apply gray and black rules, or pass the inverse results.
  logic          fin_vld;
  logic [CW-1:0] hue_w, o1, o2, o3;
  inv_t          inv_f;

  assign fin_vld = sat_vld && hue_vld;
  assign inv_f   = dly_q[DLY-1];

  always_comb begin
    if (!hue_neg) begin
      hue_w = hue_q;
    end else if (hue_q == '0) begin
      hue_w = '0;
    end else begin
      hue_w = CW'(ONE) - hue_q;
    end
    o1 = '0;
    o2 = '0;
    o3 = '0;
    unique case (sb_o.op)
      rhc_pkg::OP_RGB2HSL: begin
        o3 = sb_o.lum;
        if (!sb_o.gray) begin
          o1 = hue_w;
          o2 = sat_q;
        end
      end
      rhc_pkg::OP_RGB2HSV: begin
        if (!sb_o.black) begin
          o3 = sb_o.mx;
          if ((32'(sat_q) > 32'(sb_o.thr)) && sb_o.dpos) begin
            o1 = hue_w;
            o2 = sat_q;
          end
        end
      end
      rhc_pkg::OP_HSL2RGB: begin
        o1 = inv_f.l1;
        o2 = inv_f.l2;
        o3 = inv_f.l3;
      end
      rhc_pkg::OP_HSV2RGB: begin
        o1 = inv_f.v1;
        o2 = inv_f.v2;
        o3 = inv_f.v3;
      end
    endcase
  end

  // Output register: one result beat per strobe.
  logic                      done_q;
  logic [rhc_pkg::OUT_W-1:0] out1_q, out2_q, out3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_vld) begin
      out1_q <= out_bits(o1);
      out2_q <= out_bits(o2);
      out3_q <= out_bits(o3);
    end
  end

  assign done_o       = done_q;
  assign out_first_o  = out1_q;
  assign out_second_o = out2_q;
  assign out_third_o  = out3_q;

  // Checks: no beat dropped entering the dividers, dividers in lockstep,
  // black rule on the HSV forward path.
  `RHC_ASSERT_NXT(a_s0_to_s1, clk_i, rst_ni, s0_vld_q, s1_vld_q)
  `RHC_ASSERT_IMP(a_div_lockstep, clk_i, rst_ni, sat_vld, hue_vld)
  `RHC_ASSERT_NXT(a_hsv_black, clk_i, rst_ni, fin_vld && (sb_o.op == rhc_pkg::OP_RGB2HSV) && sb_o.black, (out_first_o == '0) && (out_second_o == '0) && (out_third_o == '0))

endmodule

@@ rtl/core/rhc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
module rhc_div #(
  parameter int NW = 28,
  parameter int DW = 16,
  parameter int QW = 13,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] sb_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] sb_o
);

  localparam int XW = NW + DW;

  logic          vld_q [QW];
  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [SW-1:0] sb_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          vin;
    logic [NW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic [SW-1:0] sin;
    logic [XW-1:0] trial;
    logic          take;

    if (k == 0) begin : g_first
      assign vin = vld_i;
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
      assign sin = sb_i;
    end else begin : g_next
      assign vin = vld_q[k-1];
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
      assign sin = sb_q[k-1];
    end

    // Try the divisor at this bit weight; subtract when it fits.
    assign trial = XW'(din) << (QW - 1 - k);
    assign take  = (XW'(rin) >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? (rin - trial[NW-1:0]) : rin;
      den_q[k] <= din;
      quo_q[k] <= {qin[QW-2:0], take};
      sb_q[k]  <= sin;
    end
  end

  assign vld_o = vld_q[QW-1];
  assign quo_o = quo_q[QW-1];
  assign sb_o  = sb_q[QW-1];

endmodule

@@ rtl/core/rhc_hsl_rgb.sv @@
// HSL to RGB datapath: four register stages, three channel lanes.
// Depends on rhc_pkg (segment codes, threshold width).
module rhc_hsl_rgb #(
  parameter int FRAC_BITS = rhc_pkg::DEF_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic [FRAC_BITS:0]        h_i,
  input  logic [FRAC_BITS:0]        s_i,
  input  logic [FRAC_BITS:0]        l_i,
  input  logic [rhc_pkg::THR_W-1:0] thr_i,
  output logic [FRAC_BITS:0]        r_o,
  output logic [FRAC_BITS:0]        g_o,
  output logic [FRAC_BITS:0]        b_o
);

  localparam int CW    = FRAC_BITS + 1;
  localparam int ONE   = 1 << FRAC_BITS;
  localparam int THIRD = (2 * ONE + 3) / 6;

  // Stage 1: gray test, first product, the three channel hues.
  logic              gray1_q, low1_q;
  logic [2*CW:0]     mul1_q;
  logic [CW-1:0]     c1_q, s1_q;
  logic [CW-1:0]     hue1_q [3];
  logic              low_d;
  logic [CW:0]       mop_d, hp_d;
  logic [CW-1:0]     hue_d [3];

  always_comb begin
    low_d = ({l_i, 1'b0} <= (CW+1)'(ONE));
    mop_d = low_d ? ((CW+1)'(ONE) + {1'b0, s_i}) : {1'b0, s_i};
    hp_d  = {1'b0, h_i} + (CW+1)'(THIRD);
    hue_d[0] = (hp_d >= (CW+1)'(ONE)) ? CW'(hp_d - (CW+1)'(ONE)) : hp_d[CW-1:0];
    hue_d[1] = (h_i == CW'(ONE)) ? '0 : h_i;
    hue_d[2] = (h_i >= CW'(THIRD)) ? (h_i - CW'(THIRD)) : (h_i + CW'(ONE) - CW'(THIRD));
  end

  always_ff @(posedge clk_i) begin
    gray1_q <= (32'(s_i) <= 32'(thr_i));
    low1_q  <= low_d;
    mul1_q  <= {{(CW+1){1'b0}}, l_i} * {{CW{1'b0}}, mop_d};
    c1_q    <= l_i;
    s1_q    <= s_i;
    hue1_q  <= hue_d;
  end

  // Stage 2: m1, m2, span and the per-lane slope factor.
  logic                 gray2_q;
  logic [CW-1:0]        c2_q, span2_q;
  logic signed [CW+2:0] m1_2_q, m2_2_q;
  logic [CW-1:0]        k2_q [3];
  rhc_pkg::seg_e        seg2_q [3];
  logic [2*CW:0]        rsum;
  logic signed [CW+2:0] rr_s, c_s, s_s, m2_s, m1_s, sp_s;
  logic [CW+2:0]        h6 [3];
  logic [CW+2:0]        kw [3];
  logic [CW-1:0]        k_d [3];
  rhc_pkg::seg_e        seg_d [3];

  always_comb begin
    rsum = mul1_q + (2*CW+1)'(ONE / 2);
    rr_s = $signed({2'b0, rsum[FRAC_BITS+CW:FRAC_BITS]});
    c_s  = $signed({3'b0, c1_q});
    s_s  = $signed({3'b0, s1_q});
    m2_s = low1_q ? rr_s : (c_s + s_s - rr_s);
    m1_s = (c_s <<< 1) - m2_s;
    sp_s = m2_s - m1_s;
    for (int i = 0; i < 3; i++) begin
      h6[i] = ((CW+3)'(hue1_q[i]) << 2) + ((CW+3)'(hue1_q[i]) << 1);
      if (h6[i] < (CW+3)'(ONE)) begin
        seg_d[i] = rhc_pkg::SEG_RISE;
        kw[i]    = h6[i];
      end else if (((CW+3)'(hue1_q[i]) << 1) < (CW+3)'(ONE)) begin
        seg_d[i] = rhc_pkg::SEG_TOP;
        kw[i]    = '0;
      end else if ((CW+3)'(hue1_q[i]) * 3 < (CW+3)'(2 * ONE)) begin
        seg_d[i] = rhc_pkg::SEG_FALL;
        kw[i]    = (CW+3)'(4 * ONE) - h6[i];
      end else begin
        seg_d[i] = rhc_pkg::SEG_LOW;
        kw[i]    = '0;
      end
      k_d[i] = kw[i][CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    gray2_q <= gray1_q;
    c2_q    <= c1_q;
    m1_2_q  <= m1_s;
    m2_2_q  <= m2_s;
    span2_q <= sp_s[CW+2] ? '0 : sp_s[CW-1:0];
    k2_q    <= k_d;
    seg2_q  <= seg_d;
  end

  // Stage 3: one product per lane.
  logic                 gray3_q;
  logic [CW-1:0]        c3_q;
  logic signed [CW+2:0] m1_3_q, m2_3_q;
  logic [2*CW-1:0]      prod3_q [3];
  rhc_pkg::seg_e        seg3_q [3];

  always_ff @(posedge clk_i) begin
    gray3_q <= gray2_q;
    c3_q    <= c2_q;
    m1_3_q  <= m1_2_q;
    m2_3_q  <= m2_2_q;
    seg3_q  <= seg2_q;
    for (int i = 0; i < 3; i++) begin
      prod3_q[i] <= {{CW{1'b0}}, span2_q} * {{CW{1'b0}}, k2_q[i]};
    end
  end

  // Stage 4: round, pick by segment, clamp.
  logic [CW-1:0]        out_q [3];
  logic [2*CW-1:0]      rs [3];
  logic signed [CW+2:0] v [3];
  logic [CW-1:0]        out_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rs[i] = prod3_q[i] + (2*CW)'(ONE / 2);
      unique case (seg3_q[i])
        rhc_pkg::SEG_RISE,
        rhc_pkg::SEG_FALL: v[i] = m1_3_q + $signed({2'b0, rs[i][FRAC_BITS+CW:FRAC_BITS]});
        rhc_pkg::SEG_TOP:  v[i] = m2_3_q;
        default:           v[i] = m1_3_q;
      endcase
      if (gray3_q) begin
        out_d[i] = c3_q;
      end else if (v[i] < 0) begin
        out_d[i] = '0;
      end else if (v[i] > $signed((CW+3)'(ONE))) begin
        out_d[i] = CW'(ONE);
      end else begin
        out_d[i] = v[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign r_o = out_q[0];
  assign g_o = out_q[1];
  assign b_o = out_q[2];

endmodule

@@ rtl/core/rhc_hsv_rgb.sv @@
// HSV to RGB datapath: region split, products, rounding, channel select.
// Depends on rhc_pkg (threshold width); four register stages.
module rhc_hsv_rgb #(
  parameter int FRAC_BITS = rhc_pkg::DEF_FRAC_BITS
) (
  input  logic                      clk_i,
  input  logic [FRAC_BITS:0]        h_i,
  input  logic [FRAC_BITS:0]        s_i,
  input  logic [FRAC_BITS:0]        v_i,
  input  logic [rhc_pkg::THR_W-1:0] thr_i,
  output logic [FRAC_BITS:0]        r_o,
  output logic [FRAC_BITS:0]        g_o,
  output logic [FRAC_BITS:0]        b_o
);

  localparam int CW  = FRAC_BITS + 1;
  localparam int ONE = 1 << FRAC_BITS;
  localparam logic [2*CW-1:0] SQ = (2*CW)'(1) << (2 * FRAC_BITS);

  // Stage 1: region (capped at 5) and remainder.
  logic          gray1_q;
  logic [2:0]    rg1_q;
  logic [CW-1:0] rem1_q, c1_q, s1_q;
  logic [CW+2:0] h6;
  logic [2:0]    rg_raw, rg_d;

  always_comb begin
    h6     = ((CW+3)'(h_i) << 2) + ((CW+3)'(h_i) << 1);
    rg_raw = h6[CW+1:FRAC_BITS];
    rg_d   = (rg_raw > 3'd5) ? 3'd5 : rg_raw;
  end

  always_ff @(posedge clk_i) begin
    gray1_q <= (32'(s_i) <= 32'(thr_i));
    rg1_q   <= rg_d;
    rem1_q  <= CW'(h6 - ((CW+3)'(rg_d) << FRAC_BITS));
    c1_q    <= v_i;
    s1_q    <= s_i;
  end

  // Stage 2: saturation products.
  logic            gray2_q;
  logic [2:0]      rg2_q;
  logic [CW-1:0]   c2_q;
  logic [2*CW-1:0] xq2_q, xt2_q, yp2_q;

  always_ff @(posedge clk_i) begin
    gray2_q <= gray1_q;
    rg2_q   <= rg1_q;
    c2_q    <= c1_q;
    xq2_q   <= {{CW{1'b0}}, s1_q} * {{CW{1'b0}}, rem1_q};
    xt2_q   <= {{CW{1'b0}}, s1_q} * {{CW{1'b0}}, CW'(ONE) - rem1_q};
    yp2_q   <= {{CW{1'b0}}, c1_q} * {{CW{1'b0}}, CW'(ONE) - s1_q};
  end

  // Stage 3: scale by value; round p.
  logic            gray3_q;
  logic [2:0]      rg3_q;
  logic [CW-1:0]   c3_q, p3_q;
  logic [3*CW-1:0] pq3_q, pt3_q;
  logic [2*CW-1:0] yps;

  assign yps = yp2_q + (2*CW)'(ONE / 2);

  always_ff @(posedge clk_i) begin
    gray3_q <= gray2_q;
    rg3_q   <= rg2_q;
    c3_q    <= c2_q;
    p3_q    <= yps[FRAC_BITS+CW-1:FRAC_BITS];
    pq3_q   <= (3*CW)'(c2_q) * (3*CW)'(SQ - xq2_q);
    pt3_q   <= (3*CW)'(c2_q) * (3*CW)'(SQ - xt2_q);
  end

  // Stage 4: round q and t, place p, q, t by region.
  logic [CW-1:0]   r_q, g_q, b_q;
  logic [3*CW-1:0] qs, ts;
  logic [CW-1:0]   qv, tv, r_d, g_d, b_d;

  always_comb begin
    qs  = pq3_q + (3*CW)'(SQ >> 1);
    ts  = pt3_q + (3*CW)'(SQ >> 1);
    qv  = qs[2*FRAC_BITS+CW-1:2*FRAC_BITS];
    tv  = ts[2*FRAC_BITS+CW-1:2*FRAC_BITS];
    r_d = c3_q;
    g_d = c3_q;
    b_d = c3_q;
    if (!gray3_q) begin
      unique case (rg3_q)
        3'd0:    begin g_d = tv; b_d = p3_q; end
        3'd1:    begin r_d = qv; b_d = p3_q; end
        3'd2:    begin r_d = p3_q; b_d = tv; end
        3'd3:    begin r_d = p3_q; g_d = qv; end
        3'd4:    begin r_d = tv; g_d = p3_q; end
        default: begin g_d = p3_q; b_d = qv; end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    g_q <= g_d;
    b_q <= b_d;
  end

  assign r_o = r_q;
  assign g_o = g_q;
  assign b_o = b_q;

endmodule

@@ sim/tb_rgb_hsl_hsv_converter.sv @@
// Self-checking testbench of the RGB / HSL / HSV converter top level.
// Depends on rhc_pkg and the RTL of rgb_hsl_hsv_converter; reads no files.
module tb_rgb_hsl_hsv_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import rhc_pkg::*;

  localparam longint ONE      = longint'(1) << DEF_FRAC_BITS;
  localparam int     SETTLE   = DEF_FRAC_BITS + 8;   // cycles past pipeline latency
  localparam int     MAX_SHOW = 10;

  typedef struct packed {
    logic [OUT_W-1:0] first;
    logic [OUT_W-1:0] second;
    logic [OUT_W-1:0] third;
  } color_t;

  // One row of the directed table; known marks rows whose result is typed in.
  typedef struct {
    op_e              op;
    logic [IN_W-1:0]  a;
    logic [IN_W-1:0]  b;
    logic [IN_W-1:0]  c;
    bit               known;
    color_t           res;
  } vec_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [1:0]               op_i;
  logic signed [IN_W-1:0]   in_first_i, in_second_i, in_third_i;
  logic                     cfg_we_i;
  logic [THR_W-1:0]         cfg_wdata_i;
  logic                     done_o;
  logic [OUT_W-1:0]         out_first_o, out_second_o, out_third_o;

  color_t       pending_colors[$];
  longint       gray_thr;
  int           mismatches;
  vec_row_t     vec_tab[$];

  rgb_hsl_hsv_converter dut (
    .clk_i, .rst_ni, .start, .busy, .op_i,
    .in_first_i, .in_second_i, .in_third_i,
    .cfg_we_i, .cfg_wdata_i,
    .done_o, .out_first_o, .out_second_o, .out_third_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Color math, fixed point with ONE = 1.0, rounding halves away from zero
  // ---------------------------------------------------------------------
  function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
    if (d == 0) return 0;
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic longint round_div_s(longint n, longint d);
    if (d <= 0) return 0;
    if (n < 0) return -longint'(round_div(longint'(-n), d));
    return longint'(round_div(n, d));
  endfunction

  function automatic longint clip_chan(logic signed [IN_W-1:0] x);
    longint v;
    v = x;
    if (v < 0) v = 0;
    if (v > ONE) v = ONE;
    return v;
  endfunction

  function automatic longint wrap_turn(longint h);
    if (h < 0) h += ONE;
    if (h >= ONE) h -= ONE;
    return h;
  endfunction

  // Hue from whichever channel holds the max; chroma d is above zero.
  function automatic longint hue_from_rgb(longint r, longint g, longint b,
                                          longint mx, longint d);
    longint num;
    if (r >= mx) num = g - b;
    else if (g >= mx) num = 2 * d + (b - r);
    else num = 4 * d + (r - g);
    return wrap_turn(round_div_s(num * ONE, 6 * d));
  endfunction

  // One RGB channel of HSL: rise, top, fall, low segment by hue.
  function automatic longint hsl_level(longint m1, longint m2, longint h);
    longint span;
    span = m2 - m1;
    h = wrap_turn(h);
    if (span < 0) span = 0;
    if (6 * h < ONE) return m1 + longint'(round_div(span * 6 * h, ONE));
    if (2 * h < ONE) return m2;
    if (3 * h < 2 * ONE) return m1 + longint'(round_div(span * 2 * (2 * ONE - 3 * h), ONE));
    return m1;
  endfunction

  function automatic logic [OUT_W-1:0] to_out(longint v);
    if (v < 0) v = 0;
    if (v > ONE) v = ONE;
    return v[OUT_W-1:0];
  endfunction

  function automatic color_t convert_color(op_e op, logic signed [IN_W-1:0] ia,
                                           logic signed [IN_W-1:0] ib,
                                           logic signed [IN_W-1:0] ic);
    longint a, b, c, mx, mn, sum, d, den, m1, m2, third;
    longint h6, rgn, rem, p, q, t;
    longint unsigned sq;
    longint o1, o2, o3;
    color_t r;
    a = clip_chan(ia);
    b = clip_chan(ib);
    c = clip_chan(ic);
    o1 = 0; o2 = 0; o3 = 0;
    mx = a; mn = a;
    if (b > mx) mx = b;
    if (c > mx) mx = c;
    if (b < mn) mn = b;
    if (c < mn) mn = c;
    d = mx - mn;
    sq = ONE * ONE;
    case (op)
      OP_RGB2HSL: begin
        sum = mx + mn;
        o3 = round_div(sum, 2);
        if (d > gray_thr) begin
          den = (sum < ONE) ? sum : (2 * ONE - sum);
          o2 = round_div(d * ONE, den);
          o1 = hue_from_rgb(a, b, c, mx, d);
        end
      end
      OP_RGB2HSV: begin
        if (mx > gray_thr) begin
          o3 = mx;
          o2 = round_div(d * ONE, mx);
          if (o2 > gray_thr && d > 0) o1 = hue_from_rgb(a, b, c, mx, d);
          else o2 = 0;
        end
      end
      OP_HSL2RGB: begin
        o1 = c; o2 = c; o3 = c;
        if (b > gray_thr) begin
          third = round_div(ONE, 3);
          if (2 * c <= ONE) m2 = round_div(c * (ONE + b), ONE);
          else m2 = c + b - longint'(round_div(c * b, ONE));
          m1 = 2 * c - m2;
          o1 = hsl_level(m1, m2, a + third);
          o2 = hsl_level(m1, m2, a);
          o3 = hsl_level(m1, m2, a - third);
        end
      end
      default: begin
        o1 = c; o2 = c; o3 = c;
        if (b > gray_thr) begin
          h6  = a * 6;
          rgn = h6 >>> DEF_FRAC_BITS;
          if (rgn > 5) rgn = 5;   // hue of exactly one lands in the last region
          rem = h6 - rgn * ONE;
          p = round_div(c * (ONE - b), ONE);
          q = round_div(c * (sq - b * rem), sq);
          t = round_div(c * (sq - b * (ONE - rem)), sq);
          case (rgn)
            0: begin o2 = t; o3 = p; end
            1: begin o1 = q; o3 = p; end
            2: begin o1 = p; o3 = t; end
            3: begin o1 = p; o2 = q; end
            4: begin o1 = t; o2 = p; end
            default: begin o2 = p; o3 = q; end
          endcase
        end
      end
    endcase
    r.first  = to_out(o1);
    r.second = to_out(o2);
    r.third  = to_out(o3);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: every done_o beat is matched against the oldest color
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    color_t want, got;
    if (rst_ni && done_o) begin
      got = '{out_first_o, out_second_o, out_third_o};
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOW)
          $display("unexpected result beat %0d %0d %0d", got.first, got.second, got.third);
      end else begin
        want = pending_colors.pop_front();
        if (want.first !== got.first || want.second !== got.second ||
            want.third !== got.third) begin
          mismatches++;
          if (mismatches <= MAX_SHOW)
            $display("mismatch: want %0d %0d %0d got %0d %0d %0d", want.first,
                     want.second, want.third, got.first, got.second, got.third);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------
  // Hold the beat until an edge with busy low takes it; busy moves only on
  // rising edges, so a low level seen at the falling edge means acceptance.
  task automatic send_beat(op_e op, logic [IN_W-1:0] a, logic [IN_W-1:0] b,
                           logic [IN_W-1:0] c, bit known, color_t res);
    start       <= 1'b1;
    op_i        <= op;
    in_first_i  <= a;
    in_second_i <= b;
    in_third_i  <= c;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    pending_colors.push_back(known ? res : convert_color(op, a, b, c));
  endtask

  // Random pause, about one beat in four.
  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Drain every beat in flight, then let the pipe settle.
  task automatic drain;
    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gray_thr = v;
  endtask

  // Mostly legal levels, some extremes, some raw 16-bit words to hit clamping.
  function automatic logic [IN_W-1:0] pick_level();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'(ONE);
      2: return 16'(ONE - $urandom_range(0, 3));
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, ONE));
    endcase
  endfunction

  // Nudge a level by a few steps, to land near the gray limit.
  function automatic logic [IN_W-1:0] near_level(logic [IN_W-1:0] x);
    longint v;
    v = clip_chan(x) + $urandom_range(0, 12) - 6;
    return 16'(v);
  endfunction

  task automatic random_run(int count, bit allow_idle);
    op_e              op;
    logic [IN_W-1:0]  a, b, c;
    for (int i = 0; i < count; i++) begin
      op = op_e'($urandom_range(0, 3));
      a  = pick_level();
      b  = pick_level();
      c  = pick_level();
      // For RGB input, sometimes pull the channels together so the chroma
      // lands around the gray limit; for HSx input, do it to saturation.
      if ($urandom_range(0, 4) == 0) begin
        if (op == OP_RGB2HSL || op == OP_RGB2HSV) begin
          b = near_level(a);
          c = near_level(a);
        end else begin
          b = 16'(gray_thr + $urandom_range(0, 4) - 2);
        end
      end
      send_beat(op, a, b, c, 1'b0, '0);
      maybe_idle(allow_idle);
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    op_i        = OP_RGB2HSL;
    in_first_i  = '0;
    in_second_i = '0;
    in_third_i  = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    mismatches  = 0;
    gray_thr    = THR_RESET;

    // Directed rows; typed results follow from the formulas at a glance.
    vec_tab.push_back('{OP_RGB2HSL, 16'd0,     16'd0,     16'd0,     1, '{13'd0, 13'd0, 13'd0}});
    vec_tab.push_back('{OP_RGB2HSL, 16'd4096,  16'd4096,  16'd4096,  1, '{13'd0, 13'd0, 13'd4096}});
    vec_tab.push_back('{OP_RGB2HSL, 16'd4096,  16'd0,     16'd0,     1, '{13'd0, 13'd4096, 13'd2048}});
    vec_tab.push_back('{OP_RGB2HSL, 16'h7FFF,  16'h8000,  16'h8000,  1, '{13'd0, 13'd4096, 13'd2048}});
    vec_tab.push_back('{OP_RGB2HSL, 16'd1000,  16'd1004,  16'd1002,  1, '{13'd0, 13'd0, 13'd1002}});
    vec_tab.push_back('{OP_RGB2HSL, 16'd0,     16'd4096,  16'd0,     0, '0});
    vec_tab.push_back('{OP_RGB2HSL, 16'd0,     16'd0,     16'd4096,  0, '0});
    vec_tab.push_back('{OP_RGB2HSL, 16'd4096,  16'd0,     16'd1,     0, '0});
    vec_tab.push_back('{OP_RGB2HSV, 16'd4096,  16'd0,     16'd0,     1, '{13'd0, 13'd4096, 13'd4096}});
    vec_tab.push_back('{OP_RGB2HSV, 16'd3,     16'd1,     16'd0,     1, '{13'd0, 13'd0, 13'd0}});
    vec_tab.push_back('{OP_RGB2HSV, 16'd4096,  16'd4095,  16'd4094,  1, '{13'd0, 13'd0, 13'd4096}});
    vec_tab.push_back('{OP_RGB2HSV, 16'd1200,  16'd3000,  16'd700,   0, '0});
    vec_tab.push_back('{OP_HSL2RGB, 16'd1234,  16'd0,     16'd1000,  1, '{13'd1000, 13'd1000, 13'd1000}});
    vec_tab.push_back('{OP_HSL2RGB, 16'd0,     16'd4096,  16'd2048,  0, '0});
    vec_tab.push_back('{OP_HSL2RGB, 16'd4096,  16'd4096,  16'd3000,  0, '0});
    vec_tab.push_back('{OP_HSL2RGB, 16'hFFFF,  16'h7FFF,  16'd4096,  0, '0});
    vec_tab.push_back('{OP_HSL2RGB, 16'd2731,  16'd2000,  16'd1500,  0, '0});
    vec_tab.push_back('{OP_HSV2RGB, 16'd4096,  16'd4096,  16'd4096,  1, '{13'd4096, 13'd0, 13'd0}});
    vec_tab.push_back('{OP_HSV2RGB, 16'd500,   16'd4,     16'd3000,  1, '{13'd3000, 13'd3000, 13'd3000}});
    vec_tab.push_back('{OP_HSV2RGB, 16'h8000,  16'd4096,  16'h7FFF,  1, '{13'd4096, 13'd0, 13'd0}});
    vec_tab.push_back('{OP_HSV2RGB, 16'd683,   16'd4096,  16'd4096,  0, '0});
    vec_tab.push_back('{OP_HSV2RGB, 16'd2048,  16'd2500,  16'd1800,  0, '0});
    vec_tab.push_back('{OP_HSV2RGB, 16'd3413,  16'd1,     16'd0,     0, '0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vec_tab[i]) begin
      send_beat(vec_tab[i].op, vec_tab[i].a, vec_tab[i].b, vec_tab[i].c,
                vec_tab[i].known, vec_tab[i].res);
      maybe_idle(1'b1);
    end

    // Walk the gray limit through its extremes; each write drains first.
    write_threshold(13'd0);
    random_run(350, 1'b1);
    write_threshold(13'd4096);   // every color counts gray
    random_run(150, 1'b1);
    write_threshold(13'd300);
    random_run(330, 1'b1);
    write_threshold(13'(THR_RESET));
    random_run(300, 1'b1);
    // Close with back-to-back beats, no idling at all.
    random_run(200, 1'b0);

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
